/* hdl/tdoa_pkg.sv */
// Shared types, field layout and codes of the microphone-pair delay generator.
package tdoa_pkg;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIC_COUNT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLES_PM  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_LEN   = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Item kinds carried on the request tuser bit.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // Field widths.
   localparam int COORD_W   = 16;
   localparam int SLOT_W    = 3;
   localparam int PAIR_W    = 5;
   localparam int MIC_W     = 3;
   localparam int FINE_W    = 24;
   localparam int RND_W     = 16;
   localparam int WRAP_W    = 12;
   localparam int COUNT_W   = 4;
   localparam int SPM_W     = 16;
   localparam int FLEN_W    = 13;

   // Request tdata layout, lowest bit first.
   localparam int REQ_DATA_W = 56;
   localparam int REQ_X_LSB  = SLOT_W;
   localparam int REQ_Y_LSB  = REQ_X_LSB + COORD_W;
   localparam int REQ_Z_LSB  = REQ_Y_LSB + COORD_W;

   // Response tdata layout, lowest bit first.
   localparam int RSP_DATA_W   = 64;
   localparam int RSP_FIRST_LSB  = PAIR_W;
   localparam int RSP_SECOND_LSB = RSP_FIRST_LSB + MIC_W;
   localparam int RSP_FINE_LSB   = RSP_SECOND_LSB + MIC_W;
   localparam int RSP_RND_LSB    = RSP_FINE_LSB + FINE_W;
   localparam int RSP_WRAP_LSB   = RSP_RND_LSB + RND_W;
   localparam int RSP_USED_W     = RSP_WRAP_LSB + WRAP_W;

   // Register reset values and limits.
   localparam logic [COUNT_W-1:0] MIC_COUNT_RST = 4'd8;
   localparam logic [SPM_W-1:0]   SPM_RST       = 16'd11942;
   localparam logic [FLEN_W-1:0]  FLEN_RST      = 13'd512;
   localparam logic [FLEN_W-1:0]  FLEN_MAX      = 13'd4096;

   // Arithmetic widths.
   localparam int DIFF_W = COORD_W + 1;     // per-axis difference
   localparam int MUL_W  = 18;              // shared multiplier operand width
   localparam int PROD_W = 2 * MUL_W;
   localparam int SUM_W  = 34;              // sum of three squares
   localparam int DIST_W = 17;              // square root of the sum

   typedef logic [COORD_W-1:0] coord_type;
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;

endpackage

/* hdl/tdoa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tdoa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mic_pair_tdoa_generator.sv */
// Top level: microphone-pair delay generator with a shared multiplier sequencer.
// A position load writes the table directly. A point reads each microphone, sums its three
// squared differences on the shared multiplier and builds its distance root bit by bit, then
// gives each pair a read, a multiply, two rounding steps, a 16-step modulo and an emit, with
// an extra read state at the start of each row; rsp_tready stalls hold the emit.
// Reset is synchronous and active high; the position table stays unknown until written.
module mic_pair_tdoa_generator #(
   parameter int MAX_MICS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request item.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdoa_pkg::REQ_DATA_W-1:0]    req_tdata,  // mic_slot, pos_x, pos_y, pos_z
   input  logic                               req_tuser,  // func
   // Result item.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tdoa_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // pair_index, first_mic,
                                                          // second_mic, delay_fine,
                                                          // delay_rounded, delay_wrapped
   output logic                               rsp_tlast,  // last_pair
   // Configuration writes.
   input  logic                               csr_wen,
   input  logic [tdoa_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tdoa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tdoa_pkg::*;

   localparam int IDX_W   = $clog2(MAX_MICS);
   localparam int CNT_W   = $clog2(MAX_MICS + 1);
   localparam int NPAIR_W = $clog2(MAX_MICS * (MAX_MICS - 1) / 2 + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_D_RD, ST_D_MUL, ST_D_ACC, ST_D_SQRT,
      ST_P_RDI, ST_P_LATI, ST_P_RDJ, ST_P_MUL, ST_P_FINE, ST_P_RND,
      ST_P_MODI, ST_P_MOD, ST_P_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [COUNT_W-1:0] mic_count_ff, mic_count_in;
   logic [SPM_W-1:0]   spm_ff, spm_in;
   logic [FLEN_W-1:0]  flen_ff, flen_in;

   // Sequencer registers.
   point_type            pt_ff, pt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [1:0]           k_ff, k_in;
   logic [NPAIR_W-1:0]   pair_ff, pair_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     sq_v_ff, sq_v_in;
   logic [SUM_W-1:0]     sq_res_ff, sq_res_in;
   logic [SUM_W-1:0]     sq_bit_ff, sq_bit_in;
   logic [DIST_W-1:0]    di_ff, di_in;
   logic signed [FINE_W-1:0] fine_ff, fine_in;
   logic signed [RND_W-1:0]  rnd_ff, rnd_in;
   logic [RND_W-1:0]     msh_ff, msh_in;
   logic [WRAP_W-1:0]    rem_ff, rem_in;
   logic [4:0]           mcnt_ff, mcnt_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memories.
   logic                      mic_wen;
   logic [3*COORD_W-1:0]      mic_rdata;
   logic                      dist_wen;
   logic [IDX_W-1:0]          dist_raddr;
   logic [DIST_W-1:0]         dist_rdata;

   // Combinational helpers.
   logic                      req_fire;
   point_type                 req_pt;
   logic [SLOT_W-1:0]         req_slot;
   logic [FLEN_W-1:0]         len;
   logic [COUNT_W-1:0]        n_cap;
   point_type                 mic_pt;
   logic signed [DIFF_W-1:0]  dx;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [MUL_W-1:0]   diff;
   logic [SUM_W:0]            sq_try;
   logic [PROD_W-1:0]         pmag, pround;
   logic [FINE_W-1:0]         fmag;
   logic [FINE_W-1:0]         fround;
   logic [WRAP_W:0]           rem_try;
   logic [FLEN_W-1:0]         wrap_neg;
   logic [WRAP_W-1:0]         wrap_val;
   logic                      emit_ok;
   logic                      at_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_pt.x   = req_tdata[REQ_X_LSB +: COORD_W];
   assign req_pt.y   = req_tdata[REQ_Y_LSB +: COORD_W];
   assign req_pt.z   = req_tdata[REQ_Z_LSB +: COORD_W];
   assign len        = (flen_ff > FLEN_MAX) ? FLEN_MAX : flen_ff;
   assign n_cap      = (mic_count_ff > COUNT_W'(MAX_MICS)) ? COUNT_W'(MAX_MICS)
                                                           : mic_count_ff;
   assign mic_pt     = point_type'(mic_rdata);

   // Position writes land directly in the table; slots past the table are dropped.
   assign mic_wen = req_fire && (req_tuser == FUNC_LOAD)
                    && ({1'b0, req_slot} < 4'(MAX_MICS));

   tdoa_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_MICS)) u_mic_ram (
      .clock   (clock),
      .wr_en   (mic_wen),
      .wr_addr (IDX_W'(req_slot)),
      .wr_data (req_pt),
      .rd_addr (i_ff[IDX_W-1:0]),
      .rd_data (mic_rdata)
   );

   assign dist_wen   = (state_ff == ST_D_SQRT) && (sq_bit_ff == '0);
   assign dist_raddr = (state_ff == ST_P_RDI) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   tdoa_ram #(.WIDTH(DIST_W), .DEPTH(MAX_MICS)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wen),
      .wr_addr (i_ff[IDX_W-1:0]),
      .wr_data (sq_res_ff[DIST_W-1:0]),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   // Per-axis difference of the microphone and the point.
   always_comb begin
      unique case (k_ff)
         2'd0:    dx = DIFF_W'(signed'(mic_pt.x)) - DIFF_W'(signed'(pt_ff.x));
         2'd1:    dx = DIFF_W'(signed'(mic_pt.y)) - DIFF_W'(signed'(pt_ff.y));
         default: dx = DIFF_W'(signed'(mic_pt.z)) - DIFF_W'(signed'(pt_ff.z));
      endcase
   end

   // The one multiplier serves both the squares and the scale product.
   assign diff  = signed'({1'b0, di_ff}) - signed'({1'b0, dist_rdata});
   assign mul_a = (state_ff == ST_P_MUL) ? diff : MUL_W'(dx);
   assign mul_b = (state_ff == ST_P_MUL) ? signed'({2'b00, spm_ff}) : MUL_W'(dx);

   // One root bit per cycle.
   assign sq_try = {1'b0, sq_v_ff} - ({1'b0, sq_res_ff} + {1'b0, sq_bit_ff});

   // Fine delay: divide the product by 4096, rounding half away from zero.
   assign pmag   = mul_ff[PROD_W-1] ? PROD_W'(-mul_ff) : PROD_W'(mul_ff);
   assign pround = (pmag + PROD_W'(2048)) >> 12;

   // Whole-sample delay: divide the fine delay by 256 the same way.
   assign fmag   = fine_ff[FINE_W-1] ? FINE_W'(-fine_ff) : FINE_W'(fine_ff);
   assign fround = (fmag + FINE_W'(128)) >> 8;

   assign rem_try  = {rem_ff, msh_ff[RND_W-1]};
   assign wrap_neg = len - FLEN_W'(rem_ff);
   always_comb begin
      priority if (len == '0) begin
         wrap_val = '0;
      end else if (rnd_ff[RND_W-1] && (rem_ff != '0)) begin
         wrap_val = wrap_neg[WRAP_W-1:0];
      end else begin
         wrap_val = rem_ff;
      end
   end

   assign emit_ok = !rsp_valid_ff || rsp_tready;
   assign at_last = (i_ff == n_ff - CNT_W'(2)) && (j_ff == n_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      mic_count_in = mic_count_ff;
      spm_in       = spm_ff;
      flen_in      = flen_ff;
      pt_in        = pt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pair_in      = pair_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      di_in        = di_ff;
      fine_in      = fine_ff;
      rnd_in       = rnd_ff;
      msh_in       = msh_ff;
      rem_in       = rem_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wen) begin
         unique case (csr_addr)
            CSR_MIC_COUNT:  mic_count_in = csr_wdata[COUNT_W-1:0];
            CSR_SAMPLES_PM: spm_in       = csr_wdata[SPM_W-1:0];
            CSR_FRAME_LEN:  flen_in      = csr_wdata[FLEN_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == FUNC_EVAL) && (n_cap >= 4'd2)) begin
               pt_in    = req_pt;
               n_in     = CNT_W'(n_cap);
               i_in     = '0;
               pair_in  = '0;
               state_in = ST_D_RD;
            end
         end
         ST_D_RD: begin
            k_in     = 2'd0;
            acc_in   = '0;
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_in   = mul_a * mul_b;
            state_in = ST_D_ACC;
         end
         ST_D_ACC: begin
            acc_in = acc_ff + SUM_W'(mul_ff);
            if (k_ff == 2'd2) begin
               sq_v_in   = acc_ff + SUM_W'(mul_ff);
               sq_res_in = '0;
               sq_bit_in = SUM_W'(1) << (SUM_W - 2);
               state_in  = ST_D_SQRT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_D_MUL;
            end
         end
         ST_D_SQRT: begin
            if (sq_bit_ff == '0) begin
               if (i_ff == n_ff - CNT_W'(1)) begin
                  i_in     = '0;
                  j_in     = CNT_W'(1);
                  state_in = ST_P_RDI;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_D_RD;
               end
            end else begin
               if (!sq_try[SUM_W]) begin
                  sq_v_in   = sq_try[SUM_W-1:0];
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         ST_P_RDI: begin
            state_in = ST_P_LATI;
         end
         ST_P_LATI: begin
            di_in    = dist_rdata;
            state_in = ST_P_MUL;
         end
         ST_P_RDJ: begin
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            mul_in   = mul_a * mul_b;
            state_in = ST_P_FINE;
         end
         ST_P_FINE: begin
            if (mul_ff[PROD_W-1]) begin
               fine_in = (pround > PROD_W'(8388608)) ? signed'(FINE_W'(24'h800000))
                                                     : FINE_W'(-pround);
            end else begin
               fine_in = (pround > PROD_W'(8388607)) ? signed'(FINE_W'(24'h7FFFFF))
                                                     : FINE_W'(pround);
            end
            state_in = ST_P_RND;
         end
         ST_P_RND: begin
            if (fine_ff[FINE_W-1]) begin
               rnd_in = (fround > FINE_W'(32768)) ? signed'(RND_W'(16'h8000))
                                                  : RND_W'(-fround);
            end else begin
               rnd_in = (fround > FINE_W'(32767)) ? signed'(RND_W'(16'h7FFF))
                                                  : RND_W'(fround);
            end
            state_in = ST_P_MODI;
         end
         ST_P_MODI: begin
            msh_in   = rnd_ff[RND_W-1] ? RND_W'(-rnd_ff) : RND_W'(rnd_ff);
            rem_in   = '0;
            mcnt_in  = '0;
            state_in = ST_P_MOD;
         end
         ST_P_MOD: begin
            // Restoring remainder of the magnitude, one dividend bit per cycle.
            if ({1'b0, rem_try} >= {1'b0, len}) begin
               rem_in = WRAP_W'(FLEN_W'(rem_try) - len);
            end else begin
               rem_in = WRAP_W'(rem_try);
            end
            msh_in  = msh_ff << 1;
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'(RND_W - 1)) begin
               state_in = ST_P_EMIT;
            end
         end
         ST_P_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = at_last;
               rsp_data_in  = '0;
               rsp_data_in[PAIR_W-1:0]              = PAIR_W'(pair_ff);
               rsp_data_in[RSP_FIRST_LSB +: MIC_W]  = MIC_W'(i_ff);
               rsp_data_in[RSP_SECOND_LSB +: MIC_W] = MIC_W'(j_ff);
               rsp_data_in[RSP_FINE_LSB +: FINE_W]  = fine_ff;
               rsp_data_in[RSP_RND_LSB +: RND_W]    = rnd_ff;
               rsp_data_in[RSP_WRAP_LSB +: WRAP_W]  = wrap_val;
               pair_in = pair_ff + NPAIR_W'(1);
               if (j_ff == n_ff - CNT_W'(1)) begin
                  if (at_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + CNT_W'(1);
                     j_in     = i_ff + CNT_W'(2);
                     state_in = ST_P_RDI;
                  end
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_P_RDJ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mic_count_ff <= MIC_COUNT_RST;
         spm_ff       <= SPM_RST;
         flen_ff      <= FLEN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mic_count_ff <= mic_count_in;
         spm_ff       <= spm_in;
         flen_ff      <= flen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_ff       <= pt_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      pair_ff     <= pair_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      di_ff       <= di_in;
      fine_ff     <= fine_in;
      rnd_ff      <= rnd_in;
      msh_ff      <= msh_in;
      rem_ff      <= rem_in;
      mcnt_ff     <= mcnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/tdoa_checker.sv */
// Port-level checks of the microphone-pair delay generator, bound to the top level.
module tdoa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tdoa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import tdoa_pkg::*;

   // A result item stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped before it was taken");

   // The pair is always ordered.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_SECOND_LSB +: MIC_W] > rsp_tdata[RSP_FIRST_LSB +: MIC_W]))
      else $error("pair is not ordered");

   // The final pair of a point must join adjacent microphones, as the last two in use are.
   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata[RSP_SECOND_LSB +: MIC_W] == rsp_tdata[RSP_FIRST_LSB +: MIC_W] + 3'd1))
      else $error("last flag on a pair that cannot be the final one");

   // Padding above the packed fields stays zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0))
      else $error("padding bits of a result item are set");

endmodule

bind mic_pair_tdoa_generator tdoa_checker u_tdoa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* verif/tb_top.sv */
// Self-checking testbench for the microphone-pair delay generator.
module tb_top;
   import tdoa_pkg::*;

   // One request item as it travels on the input stream.
   typedef struct {
      logic             func;
      logic [SLOT_W-1:0] slot;
      point_type        pos;
   } tdoa_req_type;

   // One pair result, in the order the fields sit in rsp_tdata.
   typedef struct packed {
      logic [PAIR_W-1:0] pair;
      logic [MIC_W-1:0]  first;
      logic [MIC_W-1:0]  second;
      logic [FINE_W-1:0] fine;
      logic [RND_W-1:0]  rnd;
      logic [WRAP_W-1:0] wrap;
      logic              last;
   } pair_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Items waiting to be driven, and pair results waiting to be observed.
   tdoa_req_type    pending_items[$];
   pair_result_type expected_pairs[$];
   tdoa_req_type    cur_item;

   // The testbench's own copy of the position table and the registers.
   point_type        mic_table[8];
   logic [COUNT_W-1:0] cfg_mics = MIC_COUNT_RST;
   logic [SPM_W-1:0]   cfg_spm  = SPM_RST;
   logic [FLEN_W-1:0]  cfg_flen = FLEN_RST;

   // Percentages of cycles in which the sender and the receiver hold back.
   int send_idle = 0;
   int rcv_idle  = 0;
   int error_count = 0;

   mic_pair_tdoa_generator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Floor of the square root, built up one result bit at a time.
   function automatic longint floor_sqrt(input longint v);
      longint res;
      longint trial;
      res = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = res | (longint'(1) << b);
         if (trial * trial <= v) res = trial;
      end
      return res;
   endfunction

   // Divide by 2^sh, rounding half away from zero.
   function automatic longint round_away(input longint v, input int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Applies an accepted item to the table copy, or queues the pair results of a point.
   task automatic predict_pairs(input tdoa_req_type it);
      longint          mic_dist[8];
      longint          dx, dy, dz, prod, fine, rnd, wrp, len;
      int              n, cnt, total;
      pair_result_type r;
      if (it.func == FUNC_LOAD) begin
         mic_table[it.slot] = it.pos;
         return;
      end
      // Counts above the table size saturate; fewer than two microphones give nothing.
      n = (cfg_mics > 8) ? 8 : int'(cfg_mics);
      if (n < 2) return;
      total = n * (n - 1) / 2;
      len = (cfg_flen > FLEN_MAX) ? longint'(FLEN_MAX) : longint'(cfg_flen);
      for (int i = 0; i < n; i++) begin
         dx = longint'($signed(mic_table[i].x)) - longint'($signed(it.pos.x));
         dy = longint'($signed(mic_table[i].y)) - longint'($signed(it.pos.y));
         dz = longint'($signed(mic_table[i].z)) - longint'($signed(it.pos.z));
         mic_dist[i] = floor_sqrt(dx * dx + dy * dy + dz * dz);
      end
      cnt = 0;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            prod = (mic_dist[i] - mic_dist[j]) * longint'(cfg_spm);
            fine = clamp(round_away(prod, 12), -8388608, 8388607);
            rnd  = clamp(round_away(fine, 8), -32768, 32767);
            // A zero frame length leaves the wrapped delay at zero.
            wrp = 0;
            if (len > 0) begin
               wrp = rnd % len;
               if (wrp < 0) wrp += len;
            end
            r.pair   = cnt[PAIR_W-1:0];
            r.first  = i[MIC_W-1:0];
            r.second = j[MIC_W-1:0];
            r.fine   = fine[FINE_W-1:0];
            r.rnd    = rnd[RND_W-1:0];
            r.wrap   = wrp[WRAP_W-1:0];
            r.last   = (cnt + 1 == total);
            expected_pairs.push_back(r);
            cnt++;
         end
      end
   endtask

   // Driver: predicts on each accepted item, then presents the next one unless it idles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_pairs(cur_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, cur_item.pos.z, cur_item.pos.y, cur_item.pos.x,
                              cur_item.slot};
               req_tuser  <= cur_item.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result with the oldest expected pair.
   always @(posedge clock) begin
      pair_result_type got;
      pair_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pair   = rsp_tdata[RSP_FIRST_LSB-1:0];
            got.first  = rsp_tdata[RSP_SECOND_LSB-1:RSP_FIRST_LSB];
            got.second = rsp_tdata[RSP_FINE_LSB-1:RSP_SECOND_LSB];
            got.fine   = rsp_tdata[RSP_RND_LSB-1:RSP_FINE_LSB];
            got.rnd    = rsp_tdata[RSP_WRAP_LSB-1:RSP_RND_LSB];
            got.wrap   = rsp_tdata[RSP_USED_W-1:RSP_WRAP_LSB];
            got.last   = rsp_tlast;
            if (expected_pairs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result pair=%0d mics=%0d/%0d", $time,
                        got.pair, got.first, got.second);
            end else begin
               want = expected_pairs.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: mismatch expected pair=%0d mics=%0d/%0d fine=%h rnd=%h wrap=%h last=%b",
                           $time, want.pair, want.first, want.second, want.fine, want.rnd,
                           want.wrap, want.last);
                  $display("%0t:          actual   pair=%0d mics=%0d/%0d fine=%h rnd=%h wrap=%h last=%b",
                           $time, got.pair, got.first, got.second, got.fine, got.rnd,
                           got.wrap, got.last);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   function automatic tdoa_req_type make_item(input logic func, input int slot,
                                              input int x, input int y, input int z);
      tdoa_req_type it;
      it.func  = func;
      it.slot  = slot[SLOT_W-1:0];
      it.pos.x = x[COORD_W-1:0];
      it.pos.y = y[COORD_W-1:0];
      it.pos.z = z[COORD_W-1:0];
      return it;
   endfunction

   // Random coordinate: mostly within +-12288 of the origin, sometimes full range.
   function automatic int rand_coord();
      if ($urandom_range(99) < 40) return $urandom_range(65535);
      return int'($urandom_range(24576)) - 12288;
   endfunction

   // Writes all three registers on consecutive edges, keeping the enable high throughout.
   task automatic write_regs(input int mics, input int spm, input int flen);
      logic [CSR_ADDR_W-1:0] addr[3];
      int                    val[3];
      addr = '{CSR_MIC_COUNT, CSR_SAMPLES_PM, CSR_FRAME_LEN};
      val  = '{mics, spm, flen};
      for (int k = 0; k < 3; k++) begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_addr  <= addr[k];
         csr_wdata <= val[k][CSR_DATA_W-1:0];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_mics = mics[COUNT_W-1:0];
      cfg_spm  = spm[SPM_W-1:0];
      cfg_flen = flen[FLEN_W-1:0];
   endtask

   // Waits until every item is taken and every result has arrived, then lets the block
   // finish any load or empty point still in flight before registers change again.
   task automatic drain();
      while (pending_items.size() > 0 || req_tvalid || expected_pairs.size() > 0)
         @(negedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic run_phase(input int s_idle, input int r_idle, input int mics,
                            input int spm, input int flen, input int n_items);
      send_idle = s_idle;
      rcv_idle  = r_idle;
      write_regs(mics, spm, flen);
      // Mostly points, with loads mixed in; every slot is written before this runs.
      for (int k = 0; k < n_items; k++)
         pending_items.push_back(make_item(($urandom_range(99) < 25) ? FUNC_LOAD : FUNC_EVAL,
                                           $urandom_range(7), rand_coord(), rand_coord(),
                                           rand_coord()));
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: fill every table slot first, several with the coordinate extremes, so
      // that no point ever reads an entry that was never written.
      send_idle = 26;
      rcv_idle  = 86;
      pending_items.push_back(make_item(FUNC_LOAD, 0, 0, 0, 0));
      pending_items.push_back(make_item(FUNC_LOAD, 1, 32767, 32767, 32767));
      pending_items.push_back(make_item(FUNC_LOAD, 2, -32768, -32768, -32768));
      pending_items.push_back(make_item(FUNC_LOAD, 3, 32767, -32768, 0));
      pending_items.push_back(make_item(FUNC_LOAD, 4, -32768, 32767, 12345));
      pending_items.push_back(make_item(FUNC_LOAD, 5, 4096, 0, 0));
      pending_items.push_back(make_item(FUNC_LOAD, 6, 0, 4096, -4096));
      pending_items.push_back(make_item(FUNC_LOAD, 7, -1, 1, -1));
      // Points at the corners of the coordinate range and near the origin, with reset
      // registers in effect.
      pending_items.push_back(make_item(FUNC_EVAL, 0, 0, 0, 0));
      pending_items.push_back(make_item(FUNC_EVAL, 7, 32767, 32767, 32767));
      pending_items.push_back(make_item(FUNC_EVAL, 3, -32768, -32768, -32768));
      pending_items.push_back(make_item(FUNC_EVAL, 5, 32767, -32768, 32767));
      pending_items.push_back(make_item(FUNC_EVAL, 1, 2048, 2048, 2048));
      pending_items.push_back(make_item(FUNC_LOAD, 0, 100, -200, 300));
      pending_items.push_back(make_item(FUNC_EVAL, 2, -100, 200, -300));
      drain();

      // Sender idles lightly, receiver heavily.
      run_phase(26, 86, 8, 11942, 512, 40);
      run_phase(26, 86, 2, 65535, 1, 40);
      run_phase(26, 86, 15, 0, 4096, 40);
      // Roles swapped: oversized frame length, a single microphone, a zero frame length.
      run_phase(86, 26, 5, 1, 8191, 40);
      run_phase(86, 26, 1, 300, 37, 30);
      run_phase(86, 26, 3, 40000, 0, 40);
      // No idling on either side.
      run_phase(0, 0, 8, 65535, 4095, 40);
      run_phase(0, 0, 0, 20000, 100, 20);
      run_phase(0, 0, 7, 12000, 777, 40);

      if (expected_pairs.size() > 0) error_count += expected_pairs.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #50000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
hdl/tdoa_pkg.sv
hdl/tdoa_ram.sv
hdl/mic_pair_tdoa_generator.sv
hdl/tdoa_checker.sv
verif/tb_top.sv
